[hdl/lapp_pkg.sv]
package lapp_pkg;

    localparam int LAPP_QUEUE_DEPTH = 4;

    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_LOSS  = 2'd1;
    localparam logic [1:0] CMD_ADAPT = 2'd2;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [10:0] PAYLOAD_RESET = 11'd1396;
    localparam logic [10:0] PAYLOAD_MAX   = 11'd1472;
    localparam logic [16:0] GAP_RESET     = 17'd3000;
    localparam logic [31:0] SEQ_RESET     = 32'd1;

    localparam logic [18:0] GAP_CAP_HIGH  = 19'd100000;
    localparam logic [18:0] GAP_CAP_MID   = 19'd50000;
    localparam logic [17:0] GAP_CAP_LOW   = 18'd30000;
    localparam logic [16:0] GAP_FLOOR     = 17'd1000;

    localparam logic [9:0] LOSS_HIGH = 10'd150;
    localparam logic [9:0] LOSS_MID  = 10'd80;
    localparam logic [9:0] LOSS_LOW  = 10'd30;
    localparam logic [9:0] LOSS_MIN  = 10'd5;

    // Reciprocals: x/3 = (x * RECIP3) >> 20 exact for x < 2^19,
    // x/5 = (x * RECIP5) >> 21 exact for x < 699050.
    localparam logic [18:0] RECIP3 = 19'd349526;
    localparam logic [18:0] RECIP5 = 19'd419431;

    typedef struct packed {
        logic        kind;
        logic        hdr;
        logic [31:0] seq;
        logic [7:0]  data;
        logic        last;
        logic [16:0] gap;
    } t_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

endpackage

[hdl/lapp_if.sv]
interface lapp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       last_of_buffer;
    logic [9:0] loss_tenths;

    modport source (output valid, cmd, data_byte, last_of_buffer, loss_tenths, input ready);
    modport sink (input valid, cmd, data_byte, last_of_buffer, loss_tenths, output ready);
endinterface

interface lapp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic        last_of_packet;
    logic [16:0] gap_us;
    logic        end_of_run;

    modport source (output valid, kind, out_byte, last_of_packet, gap_us, end_of_run,
                    input ready);
    modport sink (input valid, kind, out_byte, last_of_packet, gap_us, end_of_run,
                  output ready);
    modport monitor (input valid, ready, kind, out_byte, last_of_packet, gap_us,
                     end_of_run);
endinterface

[hdl/loss_adaptive_paced_packetizer_unit.sv]
// Loss-adaptive paced packetizer. Requests on i_req carry data bytes, loss
// reports and adapt ticks; results on o_res are packet bytes (four big-endian
// sequence bytes ahead of each chunk, the gap on the final byte) and pacing
// update reports. The front stage takes one request per cycle into a queue of
// QUEUE_DEPTH entries and holds requests off while that queue is full; the
// output stage delivers one result per cycle while o_res is ready, so a byte
// that opens a packet gives five results and any other request with a result
// one. An accepted adapt tick that changes the gap holds off the next request
// while the registered divide-by-constant products of the gap refresh, as does
// reset. i_cfg_data sets the payload limit; the user must write it only while
// the block is idle, which the block itself does not enforce.
module loss_adaptive_paced_packetizer_unit
    import lapp_pkg::*;
#(
    parameter int QUEUE_DEPTH = LAPP_QUEUE_DEPTH
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lapp_in_if.sink       i_req,
    lapp_out_if.source    o_res,
    input  logic          i_cfg_we,
    input  logic [10:0]   i_cfg_data
);

    logic          push;
    logic          pop;
    t_op           push_op;
    t_op           head_op;
    t_fifo_status  fifo_status;

    lapp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_op          (push_op)
    );

    lapp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (push_op),
        .i_pop    (pop),
        .o_head   (head_op),
        .o_status (fifo_status)
    );

    lapp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_op),
        .i_fifo_status (fifo_status),
        .o_pop         (pop),
        .o_res         (o_res)
    );

endmodule

[hdl/lapp_front.sv]
module lapp_front
    import lapp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lapp_in_if.sink       i_req,
    input  logic          i_cfg_we,
    input  logic [10:0]   i_cfg_data,
    input  t_fifo_status  i_fifo_status,
    output logic          o_push,
    output t_op           o_op
);

    logic [10:0] r_max_payload;
    logic [31:0] r_seq, n_seq;
    logic [10:0] r_fill, n_fill;
    logic [16:0] r_gap, n_gap;
    logic [9:0]  r_loss, n_loss;
    logic        r_pending, n_pending;
    logic        r_div_ok;
    logic [17:0] r_div3;
    logic [16:0] r_div10;

    logic        accept;
    logic [10:0] limit;
    logic [10:0] fill_inc;
    logic        close;
    logic [16:0] adapted;
    logic [18:0] gap_x3;
    logic [18:0] gap_x2;
    logic [18:0] gap_x4;
    logic [19:0] gap_x9;
    logic [37:0] prod3;
    logic [37:0] prod5;

    assign i_req.ready = !i_fifo_status.full && r_div_ok;
    assign accept = i_req.valid && i_req.ready;

    always_comb begin
        if (r_max_payload == 11'd0) begin
            limit = 11'd1;
        end else if (r_max_payload > PAYLOAD_MAX) begin
            limit = PAYLOAD_MAX;
        end else begin
            limit = r_max_payload;
        end
    end

    assign fill_inc = r_fill + 11'd1;
    assign close = i_req.last_of_buffer || (fill_inc >= limit);

    // The divided gaps are registered from r_gap and lag it; an adapt tick waits for them.
    assign gap_x2 = {1'b0, r_gap, 1'b0};
    assign gap_x3 = gap_x2 + {2'b00, r_gap};
    assign gap_x4 = {r_gap, 2'b00};
    assign gap_x9 = {r_gap, 3'b000} + {3'b000, r_gap};
    assign prod3 = 38'(gap_x4) * 38'(RECIP3);
    assign prod5 = 38'(gap_x9[19:1]) * 38'(RECIP5);

    always_comb begin
        if (r_loss > LOSS_HIGH) begin
            adapted = (gap_x3 > GAP_CAP_HIGH) ? GAP_CAP_HIGH[16:0] : gap_x3[16:0];
        end else if (r_loss > LOSS_MID) begin
            adapted = (gap_x2 > GAP_CAP_MID) ? GAP_CAP_MID[16:0] : gap_x2[16:0];
        end else if (r_loss > LOSS_LOW) begin
            adapted = (r_div3 > GAP_CAP_LOW) ? GAP_CAP_LOW[16:0] : r_div3[16:0];
        end else if (r_loss > LOSS_MIN) begin
            adapted = r_gap;
        end else begin
            adapted = (r_div10 < GAP_FLOOR) ? GAP_FLOOR : r_div10;
        end
    end

    always_comb begin
        n_seq = r_seq;
        n_fill = r_fill;
        n_gap = r_gap;
        n_loss = r_loss;
        n_pending = r_pending;
        o_push = 1'b0;
        o_op = '0;
        if (accept) begin
            case (i_req.cmd)
                CMD_DATA: begin
                    o_push = 1'b1;
                    o_op.kind = KIND_PACKET;
                    o_op.hdr = (r_fill == 11'd0);
                    o_op.seq = r_seq;
                    o_op.data = i_req.data_byte;
                    o_op.last = close;
                    o_op.gap = close ? r_gap : 17'd0;
                    if (close) begin
                        n_fill = 11'd0;
                        n_seq = r_seq + 32'd1;
                    end else begin
                        n_fill = fill_inc;
                    end
                end
                CMD_LOSS: begin
                    n_loss = i_req.loss_tenths;
                    n_pending = 1'b1;
                end
                CMD_ADAPT: begin
                    if (r_pending) begin
                        o_push = 1'b1;
                        o_op.kind = KIND_REPORT;
                        o_op.gap = adapted;
                        n_gap = adapted;
                        n_pending = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_div3 <= prod3[37:20];
        r_div10 <= prod5[37:21];
        if (!i_rst_n) begin
            r_max_payload <= PAYLOAD_RESET;
            r_seq <= SEQ_RESET;
            r_fill <= 11'd0;
            r_gap <= GAP_RESET;
            r_loss <= 10'd0;
            r_pending <= 1'b0;
            r_div_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_data;
            end
            r_seq <= n_seq;
            r_fill <= n_fill;
            r_gap <= n_gap;
            r_loss <= n_loss;
            r_pending <= n_pending;
            r_div_ok <= (n_gap == r_gap);
        end
    end

endmodule

[hdl/lapp_fifo.sv]
module lapp_fifo
    import lapp_pkg::*;
#(
    parameter int DEPTH = LAPP_QUEUE_DEPTH
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_op           i_op,
    input  logic          i_pop,
    output t_op           o_head,
    output t_fifo_status  o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/lapp_back.sv]
module lapp_back
    import lapp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_op           i_head,
    input  t_fifo_status  i_fifo_status,
    output logic          o_pop,
    lapp_out_if.source    o_res
);

    logic [2:0]  r_phase;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [16:0] r_gap;
    logic        r_eor;

    logic        load;
    logic        in_header;
    logic [7:0]  hdr_byte;

    assign load = !i_fifo_status.empty && (!r_valid || o_res.ready);
    assign in_header = i_head.hdr && !r_phase[2];
    assign o_pop = load && !in_header;

    always_comb begin
        case (r_phase[1:0])
            2'd0: hdr_byte = i_head.seq[31:24];
            2'd1: hdr_byte = i_head.seq[23:16];
            2'd2: hdr_byte = i_head.seq[15:8];
            default: hdr_byte = i_head.seq[7:0];
        endcase
    end

    assign o_res.valid = r_valid;
    assign o_res.kind = r_kind;
    assign o_res.out_byte = r_byte;
    assign o_res.last_of_packet = r_last;
    assign o_res.gap_us = r_gap;
    assign o_res.end_of_run = r_eor;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (in_header) begin
                r_kind <= KIND_PACKET;
                r_byte <= hdr_byte;
                r_last <= 1'b0;
                r_gap <= 17'd0;
                r_eor <= 1'b0;
            end else begin
                r_kind <= i_head.kind;
                r_byte <= i_head.data;
                r_last <= i_head.last;
                r_gap <= i_head.gap;
                r_eor <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= in_header ? r_phase + 3'd1 : 3'd0;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

[hdl/lapp_checker.sv]
module lapp_checker
    import lapp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last_of_packet,
    input  logic [16:0] i_gap_us,
    input  logic        i_end_of_run
);

    // A pacing report is a single result with no packet byte content.
    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind == KIND_REPORT) |->
        (i_out_byte == 8'd0 && !i_last_of_packet && i_end_of_run))
        else $error("report result malformed");

    // The closing byte of a packet is always the last result of its request.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind == KIND_PACKET && i_last_of_packet) |->
        i_end_of_run)
        else $error("packet end without end of run");

    // Only the closing byte of a packet carries the gap.
    a_gap_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_kind == KIND_PACKET && !i_last_of_packet) |->
        (i_gap_us == 17'd0))
        else $error("gap on inner packet byte");

    a_gap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_gap_us <= 17'd100000))
        else $error("gap out of range");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result withdrawn while stalled");

endmodule

bind loss_adaptive_paced_packetizer_unit lapp_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_res.valid),
    .i_ready          (o_res.ready),
    .i_kind           (o_res.kind),
    .i_out_byte       (o_res.out_byte),
    .i_last_of_packet (o_res.last_of_packet),
    .i_gap_us         (o_res.gap_us),
    .i_end_of_run     (o_res.end_of_run)
);
